>>> src/rc4_pkg.sv
// Shared types and constants for the RC4 stream cipher block.
package rc4_pkg;

  // Longest key kept; later key bytes are dropped.
  localparam logic [8:0] MAX_KEY_LEN = 9'd256;

  localparam logic KIND_KEY  = 1'b0;
  localparam logic KIND_DATA = 1'b1;

  typedef struct packed {
    logic       kind;
    logic [7:0] value;
    logic       last;
  } in_item_t;

  typedef struct packed {
    logic [7:0] out_byte;
    logic       out_last;
  } out_item_t;

  // One access to the permutation table, plus a clear back to identity.
  typedef struct packed {
    logic       en;
    logic       we;
    logic       clear;
    logic [7:0] addr;
    logic [7:0] wdata;
  } perm_req_t;

  // Key loading controls from the sequencer.
  typedef struct packed {
    logic       load;
    logic       last;
    logic       abandon;
    logic [7:0] value;
  } key_ctl_t;

endpackage

>>> src/rc4_perm_store.sv
// Single-port permutation table with per-entry written flags for identity reset.
module rc4_perm_store (
  input  logic               clk,
  input  logic               rst,
  input  rc4_pkg::perm_req_t req,
  output logic [7:0]         rdata
);

  logic [7:0]   mem [256];
  logic [255:0] filled;
  logic [7:0]   rd_mem;
  logic [7:0]   rd_addr;
  logic         rd_filled;

  // An entry never written since the last clear holds its own index.
  always_ff @(posedge clk) begin
    if (rst) begin
      filled <= '0;
    end else if (req.clear) begin
      filled <= '0;
    end else if (req.en && req.we) begin
      filled[req.addr] <= 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (req.en) begin
      if (req.we) begin
        mem[req.addr] <= req.wdata;
      end else begin
        rd_mem    <= mem[req.addr];
        rd_addr   <= req.addr;
        rd_filled <= filled[req.addr];
      end
    end
  end

  assign rdata = rd_filled ? rd_mem : rd_addr;

endmodule

>>> src/rc4_key_buf.sv
// Key byte store with fill count and key length for the key schedule.
module rc4_key_buf (
  input  logic              clk,
  input  logic              rst,
  input  rc4_pkg::key_ctl_t ctl,
  input  logic [7:0]        raddr,
  output logic [7:0]        rdata,
  output logic [8:0]        key_len
);

  logic [7:0] mem [256];
  logic [8:0] count;
  logic       loading;
  logic [8:0] base;
  logic       room;

  // A key byte arriving outside a load starts a fresh key.
  assign base = loading ? count : 9'd0;
  assign room = base < rc4_pkg::MAX_KEY_LEN;

  always_ff @(posedge clk) begin
    if (rst) begin
      count   <= '0;
      loading <= 1'b0;
    end else if (ctl.load) begin
      loading <= !ctl.last;
      if (room) begin
        count <= base + 9'd1;
      end else begin
        count <= base;
      end
    end else if (ctl.abandon) begin
      loading <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (ctl.load && room) begin
      mem[base[7:0]] <= ctl.value;
    end
    rdata <= mem[raddr];
  end

  assign key_len = (count == 9'd0) ? 9'd1 : count;

endmodule

>>> src/rc4_stream_cipher_top.sv
// RC4 stream cipher top level: sequencer around the permutation and key stores.
// A key byte is stored as it is taken; one flagged last adds a key schedule (read S[k]
// and S[j], write both back, for each of 256 steps) before the next item. A data
// byte reads S[i+1], S[j] and S[t], then writes the swap back, the last write held
// while a result waits; the result is registered and appears in the cycle after it.
// Reset (synchronous) restores the identity permutation, clears i, j and key state.
module rc4_stream_cipher_top (
  input  logic               clk,
  input  logic               rst,
  input  logic               req_valid,
  output logic               req_stall,
  input  rc4_pkg::in_item_t  req_item,
  output logic               rsp_valid,
  input  logic               rsp_stall,
  output rc4_pkg::out_item_t rsp_item
);

  localparam logic [3:0] ST_IDLE   = 4'd0;
  localparam logic [3:0] ST_SCH_RK = 4'd1;
  localparam logic [3:0] ST_SCH_RJ = 4'd2;
  localparam logic [3:0] ST_SCH_WK = 4'd3;
  localparam logic [3:0] ST_SCH_WJ = 4'd4;
  localparam logic [3:0] ST_KS_RJ  = 4'd5;
  localparam logic [3:0] ST_KS_RT  = 4'd6;
  localparam logic [3:0] ST_KS_WI  = 4'd7;
  localparam logic [3:0] ST_KS_WJ  = 4'd8;

  logic [3:0] state;
  logic [3:0] state_next;
  logic [7:0] idx_i;
  logic [7:0] idx_j;
  logic [7:0] kp;

  // Values captured during one swap step.
  logic [7:0] sa;
  logic [7:0] sb;
  logic [7:0] t_addr;
  logic [7:0] dat_q;
  logic       last_q;

  rc4_pkg::perm_req_t perm_req;
  rc4_pkg::key_ctl_t  key_ctl;
  logic [7:0]         perm_rdata;
  logic [7:0]         key_rdata;
  logic [8:0]         key_len;

  logic       req_fire;
  logic       out_free;
  logic [7:0] i_inc;
  logic [7:0] j_sched;
  logic [7:0] j_ks;
  logic [7:0] t_sum;
  logic [8:0] kp_inc;
  logic [7:0] ks;

  // Items are only taken while the sequencer is idle; a waiting result does not
  // hold up the input side because it sits in its own output register.
  assign req_stall = (state != ST_IDLE);
  assign req_fire  = req_valid && !req_stall;
  assign out_free  = !rsp_valid || !rsp_stall;

  assign i_inc   = idx_i + 8'd1;
  assign j_sched = idx_j + perm_rdata + key_rdata;
  assign j_ks    = idx_j + perm_rdata;
  assign t_sum   = sa + perm_rdata;
  assign kp_inc  = {1'b0, kp} + 9'd1;

  // The keystream entry was read before the swap was written back, so an address
  // that hits i or j takes the swapped value instead of the stale read data.
  always_comb begin
    if (t_addr == idx_i) begin
      ks = sb;
    end else if (t_addr == idx_j) begin
      ks = sa;
    end else begin
      ks = perm_rdata;
    end
  end

  assign key_ctl.load    = req_fire && (req_item.kind == rc4_pkg::KIND_KEY);
  assign key_ctl.last    = req_item.last;
  assign key_ctl.abandon = req_fire && (req_item.kind == rc4_pkg::KIND_DATA);
  assign key_ctl.value   = req_item.value;

  // Table access for each step of the sequence.
  always_comb begin
    perm_req.en    = 1'b0;
    perm_req.we    = 1'b0;
    perm_req.clear = 1'b0;
    perm_req.addr  = idx_i;
    perm_req.wdata = sa;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_item.kind == rc4_pkg::KIND_DATA) begin
            perm_req.en   = 1'b1;
            perm_req.addr = i_inc;
          end else if (req_item.last) begin
            perm_req.clear = 1'b1;
          end
        end
      end
      ST_SCH_RK: begin
        perm_req.en = 1'b1;
      end
      ST_SCH_RJ: begin
        perm_req.en   = 1'b1;
        perm_req.addr = j_sched;
      end
      ST_SCH_WK: begin
        perm_req.en    = 1'b1;
        perm_req.we    = 1'b1;
        perm_req.wdata = perm_rdata;
      end
      ST_SCH_WJ: begin
        perm_req.en   = 1'b1;
        perm_req.we   = 1'b1;
        perm_req.addr = idx_j;
      end
      ST_KS_RJ: begin
        perm_req.en   = 1'b1;
        perm_req.addr = j_ks;
      end
      ST_KS_RT: begin
        perm_req.en   = 1'b1;
        perm_req.addr = t_sum;
      end
      ST_KS_WI: begin
        perm_req.en    = 1'b1;
        perm_req.we    = 1'b1;
        perm_req.wdata = sb;
      end
      ST_KS_WJ: begin
        perm_req.en   = 1'b1;
        perm_req.we   = 1'b1;
        perm_req.addr = idx_j;
      end
      default: begin
        perm_req.en = 1'b0;
      end
    endcase
  end

  always_comb begin
    state_next = state;
    unique case (state)
      ST_IDLE: begin
        if (req_fire) begin
          if (req_item.kind == rc4_pkg::KIND_DATA) begin
            state_next = ST_KS_RJ;
          end else if (req_item.last) begin
            state_next = ST_SCH_RK;
          end
        end
      end
      ST_SCH_RK: state_next = ST_SCH_RJ;
      ST_SCH_RJ: state_next = ST_SCH_WK;
      ST_SCH_WK: state_next = ST_SCH_WJ;
      ST_SCH_WJ: state_next = (idx_i == 8'hFF) ? ST_IDLE : ST_SCH_RK;
      ST_KS_RJ:  state_next = ST_KS_RT;
      ST_KS_RT:  state_next = ST_KS_WI;
      ST_KS_WI:  state_next = ST_KS_WJ;
      ST_KS_WJ:  state_next = out_free ? ST_IDLE : ST_KS_WJ;
      default:   state_next = ST_IDLE;
    endcase
  end

  // During the schedule idx_i is the step counter k and idx_j the schedule j;
  // both end at zero, as the keystream expects.
  always_ff @(posedge clk) begin
    if (rst) begin
      state     <= ST_IDLE;
      idx_i     <= '0;
      idx_j     <= '0;
      kp        <= '0;
      rsp_valid <= 1'b0;
    end else begin
      state <= state_next;
      if (state == ST_IDLE && req_fire) begin
        if (req_item.kind == rc4_pkg::KIND_DATA) begin
          idx_i <= i_inc;
        end else if (req_item.last) begin
          idx_i <= '0;
          idx_j <= '0;
          kp    <= '0;
        end
      end
      if (state == ST_SCH_RJ) begin
        idx_j <= j_sched;
      end
      if (state == ST_KS_RJ) begin
        idx_j <= j_ks;
      end
      if (state == ST_SCH_WJ) begin
        idx_i <= i_inc;
        kp    <= (kp_inc == key_len) ? 8'd0 : kp_inc[7:0];
        if (idx_i == 8'hFF) begin
          idx_j <= '0;
        end
      end
      if (state == ST_KS_WJ && out_free) begin
        rsp_valid <= 1'b1;
      end else if (!rsp_stall) begin
        rsp_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (state == ST_IDLE && req_fire) begin
      dat_q  <= req_item.value;
      last_q <= req_item.last;
    end
    if (state == ST_SCH_RJ || state == ST_KS_RJ) begin
      sa <= perm_rdata;
    end
    if (state == ST_KS_RT) begin
      sb     <= perm_rdata;
      t_addr <= t_sum;
    end
    if (state == ST_KS_WJ && out_free) begin
      rsp_item.out_byte <= dat_q ^ ks;
      rsp_item.out_last <= last_q;
    end
  end

  rc4_perm_store u_perm (
    .clk   (clk),
    .rst   (rst),
    .req   (perm_req),
    .rdata (perm_rdata)
  );

  rc4_key_buf u_key (
    .clk     (clk),
    .rst     (rst),
    .ctl     (key_ctl),
    .raddr   (kp),
    .rdata   (key_rdata),
    .key_len (key_len)
  );

  // A last key byte starts the schedule in the next cycle.
  a_sched_start: assert property (@(posedge clk) disable iff (rst)
    (req_fire && req_item.kind == rc4_pkg::KIND_KEY && req_item.last)
      |=> (state == ST_SCH_RK))
    else $error("key schedule did not start after last key byte");

  // The schedule ends with both indices cleared.
  a_sched_end: assert property (@(posedge clk) disable iff (rst)
    (state == ST_SCH_WJ && idx_i == 8'hFF)
      |=> (state == ST_IDLE && idx_i == 8'd0 && idx_j == 8'd0))
    else $error("indices not cleared at end of key schedule");

  // A new result only comes from the final keystream step.
  a_rsp_source: assert property (@(posedge clk) disable iff (rst)
    $rose(rsp_valid) |-> ($past(state) == ST_KS_WJ))
    else $error("result raised outside the keystream write-back");

  // The last keystream step waits while the output register is full.
  a_rsp_hold: assert property (@(posedge clk) disable iff (rst)
    (state == ST_KS_WJ && !out_free) |=> (state == ST_KS_WJ))
    else $error("keystream step left while result still waiting");

endmodule

>>> bench/tb_rc4_stream_cipher_top.sv
// Self-checking testbench for the RC4 stream cipher top level, with its own keystream predictor.
module tb_rc4_stream_cipher_top;

  // The limit must be well above the slowest correct run, which covers a key schedule per
  // key, the table accesses of each data byte and both sides idling in random bursts.
  localparam int CYCLE_LIMIT = 500_000;
  // Random queuing stops once at least this many items are queued, counting only key bytes that are kept.
  localparam int RANDOM_ITEMS = 200;
  // Idling stops once fewer than this many items are waiting to be sent.
  localparam int TAIL_ITEMS = 60;
  // Cycles allowed after the last expected result, so that a stray late result is caught.
  localparam int DRAIN_CYCLES = 40;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               req_valid = 1'b0;
  logic               req_stall;
  rc4_pkg::in_item_t  req_item = '0;
  logic               rsp_valid;
  logic               rsp_stall = 1'b0;
  rc4_pkg::out_item_t rsp_item;

  rc4_stream_cipher_top u_top (
    .clk       (clk),
    .rst       (rst),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .req_item  (req_item),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp_item  (rsp_item)
  );

  initial begin
    forever #5 clk = ~clk;
  end

  // Items still to be sent, and the cipher results that are still owed by the block.
  rc4_pkg::in_item_t  pending_items[$];
  rc4_pkg::out_item_t expected_out[$];
  int                 mismatches = 0;
  int                 cycle_count = 0;

  // The testbench keeps its own copy of the cipher state. The permutation, the two stream
  // indices and the key buffer all advance as transfers are accepted on the request side.
  logic [7:0] perm [256];
  logic [7:0] ks_i = '0;
  logic [7:0] ks_j = '0;
  logic [7:0] key_bytes [256];
  logic [8:0] key_len = '0;
  logic       key_open = 1'b0;

  task automatic report_mismatch(input string what);
    $display("MISMATCH at cycle %0d: %s", cycle_count, what);
    mismatches++;
  endtask

  // This is the key schedule. The permutation is reset to the identity and stirred in 256
  // swap steps over the stored key. The stream indices are then cleared.
  task automatic rebuild_perm();
    int unsigned n;
    logic [7:0]  jj;
    logic [7:0]  tmp;
    n = (key_len == 0) ? 1 : key_len;
    for (int k = 0; k < 256; k++) perm[k] = 8'(k);
    jj = '0;
    for (int k = 0; k < 256; k++) begin
      jj = jj + perm[k] + key_bytes[k % n];
      tmp = perm[k];
      perm[k] = perm[jj];
      perm[jj] = tmp;
    end
    ks_i = '0;
    ks_j = '0;
  endtask

  // This advances the predicted cipher by one accepted transfer. A data byte owes exactly
  // one result, and a key byte owes none.
  task automatic predict_cipher(input rc4_pkg::in_item_t it);
    rc4_pkg::out_item_t res;
    logic [7:0]         tmp;
    logic [7:0]         ks_addr;
    if (it.kind == rc4_pkg::KIND_KEY) begin
      // The first key byte after data, or after a finished key, begins a fresh key.
      if (!key_open) begin
        key_len = '0;
        key_open = 1'b1;
      end
      // Bytes past the longest key are dropped. The flag on a dropped byte still counts.
      if (key_len < rc4_pkg::MAX_KEY_LEN) begin
        key_bytes[key_len[7:0]] = it.value;
        key_len = key_len + 9'd1;
      end
      if (it.last) begin
        rebuild_perm();
        key_open = 1'b0;
      end
    end else begin
      // A data byte abandons any key that is still being loaded.
      key_open = 1'b0;
      ks_i = ks_i + 8'd1;
      ks_j = ks_j + perm[ks_i];
      tmp = perm[ks_i];
      perm[ks_i] = perm[ks_j];
      perm[ks_j] = tmp;
      ks_addr = perm[ks_i] + perm[ks_j];
      res.out_byte = it.value ^ perm[ks_addr];
      res.out_last = it.last;
      expected_out.insert(expected_out.size(), res);
    end
  endtask

  function automatic void add_item(input logic kind, input logic [7:0] value,
                                   input logic last);
    rc4_pkg::in_item_t it;
    it.kind = kind;
    it.value = value;
    it.last = last;
    pending_items.insert(pending_items.size(), it);
  endfunction

  // This queues a key of random bytes. When the key is closed, the last flag is set on the
  // final byte. The function returns how many of the bytes the block will keep.
  function automatic int add_key(input int len, input bit closed);
    for (int k = 0; k < len; k++)
      add_item(rc4_pkg::KIND_KEY, 8'($urandom), closed && (k == len - 1));
    return (len > 256) ? 256 : len;
  endfunction

  // This queues one chunk of random data bytes, with the last flag on the final byte.
  function automatic int add_chunk(input int len);
    for (int k = 0; k < len; k++)
      add_item(rc4_pkg::KIND_DATA, 8'($urandom), k == len - 1);
    return len;
  endfunction

  // This is the request driver. A transfer happens at an edge where valid is high and
  // stall is low, and the prediction is made at that edge. While the block stalls, the
  // payload is held. Otherwise the driver either sends the next pending item or idles for
  // a random burst.
  int  req_gap = 0;
  int  req_calm = 0;
  logic tail_phase = 1'b0;

  always @(posedge clk) begin
    if (rst) begin
      req_valid <= 1'b0;
    end else begin
      if (req_valid && !req_stall) predict_cipher(req_item);
      if (req_calm > 0) req_calm--;
      else if ($urandom_range(0, 99) == 0) req_calm = $urandom_range(20, 80);
      tail_phase <= (pending_items.size() < TAIL_ITEMS);
      if (req_valid && req_stall) begin
        // The stalled transfer is held as it stands.
      end else if (req_gap > 0) begin
        req_gap--;
        req_valid <= 1'b0;
      end else if (pending_items.size() == 0) begin
        req_valid <= 1'b0;
      end else if (pending_items.size() >= TAIL_ITEMS && req_calm == 0 &&
                   $urandom_range(0, 3) == 0) begin
        // This cycle is idle, and req_gap sets how many more idle cycles follow.
        req_gap = $urandom_range(0, 5);
        req_valid <= 1'b0;
      end else begin
        req_item <= pending_items.pop_front();
        req_valid <= 1'b1;
      end
    end
  end

  // This is the result monitor. Each accepted result is checked field by field against the
  // oldest expectation. The side that receives results stalls the block in random bursts.
  int rsp_hold = 0;
  int rsp_calm = 0;

  always @(posedge clk) begin
    if (rst) begin
      rsp_stall <= 1'b0;
    end else begin
      if (rsp_valid && !rsp_stall) begin
        if (expected_out.size() == 0) begin
          report_mismatch($sformatf("result %02h/%0b arrived with none expected",
                                    rsp_item.out_byte, rsp_item.out_last));
        end else begin
          rc4_pkg::out_item_t want;
          want = expected_out.pop_front();
          if (rsp_item.out_byte !== want.out_byte)
            report_mismatch($sformatf("out_byte %02h, expected %02h",
                                      rsp_item.out_byte, want.out_byte));
          if (rsp_item.out_last !== want.out_last)
            report_mismatch($sformatf("out_last %0b, expected %0b",
                                      rsp_item.out_last, want.out_last));
        end
      end
      if (rsp_calm > 0) rsp_calm--;
      else if ($urandom_range(0, 99) == 0) rsp_calm = $urandom_range(20, 80);
      if (rsp_hold > 0) begin
        rsp_hold--;
        rsp_stall <= 1'b1;
      end else if (!tail_phase && rsp_calm == 0 && $urandom_range(0, 3) == 0) begin
        rsp_hold = $urandom_range(0, 5);
        rsp_stall <= 1'b1;
      end else begin
        rsp_stall <= 1'b0;
      end
    end
  end

  // This is the watchdog. A run that hangs ends here as a failure.
  always @(posedge clk) begin
    cycle_count++;
    if (cycle_count > CYCLE_LIMIT) begin
      $display("CHECKS FAILED");
      $finish;
    end
  end

  initial begin
    int made;
    int pick;
    int master_len;
    // The predictor starts in the reset state, which is the identity permutation.
    for (int k = 0; k < 256; k++) begin
      perm[k] = 8'(k);
      key_bytes[k] = '0;
    end

    // The directed part comes first.
    // Data sent before any key runs on the reset permutation.
    add_item(rc4_pkg::KIND_DATA, 8'h00, 1'b0);
    add_item(rc4_pkg::KIND_DATA, 8'hFF, 1'b1);
    // Here a data byte arrives partway through a key and throws the partial key away.
    add_item(rc4_pkg::KIND_KEY, 8'h00, 1'b0);
    add_item(rc4_pkg::KIND_KEY, 8'hFF, 1'b0);
    add_item(rc4_pkg::KIND_DATA, 8'h5A, 1'b0);
    // A single key byte flagged last starts a new key and schedules it at once.
    add_item(rc4_pkg::KIND_KEY, 8'hFF, 1'b1);
    add_item(rc4_pkg::KIND_DATA, 8'h00, 1'b0);
    add_item(rc4_pkg::KIND_DATA, 8'hFF, 1'b1);
    // This is an ordinary master key followed by the salt. The stream then runs on over
    // two chunks.
    made = add_key(32, 1'b1);
    made = add_chunk(3);
    made = add_chunk(2);
    // This key is too long. The bytes past the limit are dropped, and the dropped last byte
    // still starts the schedule.
    made = add_key(260, 1'b1);
    made = add_chunk(4);

    // The random part is mostly well-formed sessions of master key, salt and data chunks.
    // Stray items and broken keys are mixed in among them.
    made = 0;
    while (made < RANDOM_ITEMS) begin
      pick = $urandom_range(0, 9);
      if (pick < 7) begin
        master_len = ($urandom_range(0, 19) == 0) ? $urandom_range(17, 250)
                                                   : $urandom_range(1, 16);
        made += add_key(master_len + 16, 1'b1);
        repeat ($urandom_range(1, 4)) made += add_chunk($urandom_range(1, 12));
      end else if (pick < 9) begin
        repeat ($urandom_range(1, 8)) begin
          add_item(1'($urandom), 8'($urandom), $urandom_range(0, 3) == 0);
          made++;
        end
      end else begin
        made += add_key($urandom_range(1, 20), 1'b0);
        made += add_chunk($urandom_range(1, 6));
      end
    end

    repeat (6) @(posedge clk);
    rst <= 1'b0;

    // Every item must be sent and every expected result received before the drain.
    while (pending_items.size() != 0 || req_valid) @(posedge clk);
    while (expected_out.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0) begin
      $display("ALL CHECKS PASSED");
    end else begin
      $display("CHECKS FAILED");
    end
    $finish;
  end

endmodule

>>> rc4_stream_cipher_top.f
src/rc4_pkg.sv
src/rc4_perm_store.sv
src/rc4_key_buf.sv
src/rc4_stream_cipher_top.sv
bench/tb_rc4_stream_cipher_top.sv
